// File: rtl/rrlt_pkg.sv
// Package for the RF remote learn table: sizes, codes, state machine and
// controller/datapath interface types. No dependencies.
`timescale 1ns / 1ps

package rrlt_pkg;

  localparam int SLOTS   = 8;
  localparam int BUTTONS = 4;

  localparam int CODE_W  = 32;
  localparam int REG_W   = 4;
  localparam int OUT_W   = 4;                      // slot_number / stored_count ports
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int BTN_W   = $clog2(BUTTONS);

  localparam logic [CODE_W-1:0] A_TYPE_LIMIT = 32'h2390_0000;
  localparam logic [CODE_W-1:0] A_ADDR_MASK  = 32'hFFFF_F0FF;
  localparam logic [CODE_W-1:0] B_ADDR_MASK  = 32'hFFFF_FFF0;

  localparam logic [BUTTONS-1:0][REG_W-1:0] B_TYPE_BITS  = {4'h8, 4'h4, 4'h2, 4'h1};
  localparam logic [BUTTONS-1:0][REG_W-1:0] A_CODE_RESET = {4'h8, 4'h4, 4'h2, 4'h1};

  typedef logic [BUTTONS-1:0][CODE_W-1:0] btn_row_t;

  typedef enum logic [1:0] {
    OP_LEARN    = 2'd0,
    OP_FIND     = 2'd1,
    OP_DEL_LAST = 2'd2,
    OP_DEL_ALL  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EXISTS  = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SEL_NONE,   // slot number zero
    SEL_HIT,    // slot of the matching entry
    SEL_NEW,    // slot being appended
    SEL_TOP     // slot being removed
  } slot_sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DELETE
  } state_t;

  typedef struct packed {
    logic      accept;     // latch item, restart scan
    logic      scan_en;    // advance read pipeline
    logic      write_en;   // append entry, bump count
    logic      del_last;
    logic      del_all;
    logic      res_load;   // load result register
    status_t   res_status;
    slot_sel_t res_slot;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic hit;
    logic miss;
  } stat_t;

endpackage

// File: rtl/rrlt_datapath.sv
// Datapath of the RF remote learn table: config registers, slot memories,
// scan pipeline, count and result register. Depends on rrlt_pkg.
`timescale 1ns / 1ps

module rrlt_datapath import rrlt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [REG_W-1:0]  cfg_wdata,
  input  logic [1:0]        in_operation,
  input  logic [CODE_W-1:0] in_rf_code,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic [2:0]        out_status,
  output logic [OUT_W-1:0]  out_slot_number,
  output logic [OUT_W-1:0]  out_stored_count
);

  logic [REG_W-1:0]  a_code_r [BUTTONS];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rd_ptr_r;
  logic              q_valid_r;
  logic [SLOT_W-1:0] q_slot_r;
  logic [CODE_W-1:0] q_addr_r;
  btn_row_t          q_btn_r;
  op_t               op_r;
  logic [CODE_W-1:0] code_r;

  logic [CODE_W-1:0] addr_mem [SLOTS];
  btn_row_t          btn_mem  [SLOTS];

  logic              a_type;
  logic [CODE_W-1:0] learn_addr;
  btn_row_t          new_row;
  logic              btn_hit;
  logic [CNT_W-1:0]  res_slot;

  logic [2:0]        res_status_r;
  logic [OUT_W-1:0]  res_slot_r;
  logic [OUT_W-1:0]  res_count_r;

  assign a_type     = (code_r >= A_TYPE_LIMIT);
  assign learn_addr = a_type ? (code_r & A_ADDR_MASK) : (code_r & B_ADDR_MASK);

  always_comb begin
    for (int b = 0; b < BUTTONS; b++) begin
      if (a_type) begin
        new_row[b] = learn_addr | {{(CODE_W-REG_W-8){1'b0}}, a_code_r[b], 8'h00};
      end else begin
        new_row[b] = learn_addr | {{(CODE_W-REG_W){1'b0}}, B_TYPE_BITS[b]};
      end
    end
  end

  always_comb begin
    btn_hit = 1'b0;
    for (int b = 0; b < BUTTONS; b++) begin
      if (q_btn_r[b] == code_r) begin
        btn_hit = 1'b1;
      end
    end
  end

  assign stat.op    = op_r;
  assign stat.full  = (count_r == CNT_W'(SLOTS));
  assign stat.empty = (count_r == '0);
  assign stat.hit   = q_valid_r && ((op_r == OP_LEARN) ? (q_addr_r == learn_addr) : btn_hit);
  assign stat.miss  = !q_valid_r && (rd_ptr_r >= count_r);

  always_comb begin
    count_nxt = count_r;
    if (cmd.del_all) begin
      count_nxt = '0;
    end else if (cmd.del_last) begin
      count_nxt = count_r - 1'b1;
    end else if (cmd.write_en) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_comb begin
    case (cmd.res_slot)
      SEL_NONE: res_slot = '0;
      SEL_HIT:  res_slot = CNT_W'(q_slot_r) + 1'b1;
      SEL_NEW:  res_slot = count_r + 1'b1;
      SEL_TOP:  res_slot = count_r;
      default:  res_slot = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BUTTONS; b++) begin
        a_code_r[b] <= A_CODE_RESET[b];
      end
      count_r   <= '0;
      rd_ptr_r  <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        a_code_r[cfg_index] <= cfg_wdata;
      end
      count_r <= count_nxt;
      if (cmd.accept) begin
        rd_ptr_r  <= '0;
        q_valid_r <= 1'b0;
      end else if (cmd.scan_en) begin
        q_valid_r <= (rd_ptr_r < count_r);
        if (rd_ptr_r < count_r) begin
          rd_ptr_r <= rd_ptr_r + 1'b1;
        end
      end
    end
  end

  // item, read data and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= op_t'(in_operation);
      code_r <= in_rf_code;
    end
    if (cmd.scan_en) begin
      q_addr_r <= addr_mem[rd_ptr_r[SLOT_W-1:0]];
      q_btn_r  <= btn_mem[rd_ptr_r[SLOT_W-1:0]];
      q_slot_r <= rd_ptr_r[SLOT_W-1:0];
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_slot_r   <= OUT_W'(res_slot);
      res_count_r  <= OUT_W'(count_nxt);
    end
  end

  // append at the top slot; entries at or above the count are never used
  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      addr_mem[count_r[SLOT_W-1:0]] <= learn_addr;
      btn_mem[count_r[SLOT_W-1:0]]  <= new_row;
    end
  end

  assign out_status       = res_status_r;
  assign out_slot_number  = res_slot_r;
  assign out_stored_count = res_count_r;

endmodule

// File: rtl/rrlt_ctrl.sv
// Controller of the RF remote learn table: sequences scan, append and
// delete, and owns both handshakes. Depends on rrlt_pkg.
`timescale 1ns / 1ps

module rrlt_ctrl import rrlt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  output logic       out_valid,
  input  logic       out_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_LEARN || in_operation == OP_FIND) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DELETE;
          end
        end
      end
      S_SCAN: begin
        if (out_free && ((stat.op == OP_LEARN && stat.full) || stat.hit || stat.miss)) begin
          state_nxt = S_IDLE;
        end
      end
      S_DELETE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.res_status = ST_OK;
    cmd.res_slot   = SEL_NONE;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
      end
      S_SCAN: begin
        if (out_free) begin
          if (stat.op == OP_LEARN && stat.full) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_FULL;
          end else if (stat.hit) begin
            cmd.res_load = 1'b1;
            if (stat.op == OP_LEARN) begin
              cmd.res_status = ST_EXISTS;
            end else begin
              cmd.res_slot = SEL_HIT;
            end
          end else if (stat.miss) begin
            cmd.res_load = 1'b1;
            if (stat.op == OP_LEARN) begin
              cmd.write_en = 1'b1;
              cmd.res_slot = SEL_NEW;
            end else begin
              cmd.res_status = ST_UNKNOWN;
            end
          end else begin
            cmd.scan_en = 1'b1;
          end
        end
      end
      S_DELETE: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          if (stat.op == OP_DEL_ALL) begin
            cmd.del_all = 1'b1;
          end else if (stat.empty) begin
            cmd.res_status = ST_EMPTY;
          end else begin
            cmd.del_last = 1'b1;
            cmd.res_slot = SEL_TOP;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/rf_remote_learn_table.sv
// Top level of the RF remote learn table: controller plus datapath.
// Depends on rrlt_pkg, rrlt_ctrl and rrlt_datapath.
//
//   channel | ports                                      | accepted when
//   --------+--------------------------------------------+------------------------
//   in      | in_operation, in_rf_code                   | in_valid && in_ready
//   out     | out_status, out_slot_number, out_stored_count | out_valid && out_ready
//   cfg     | cfg_we, cfg_index, cfg_wdata               | cfg_we
//
// One item at a time. Learn and find scan the stored slots through a
// registered memory read, one slot per cycle while the result is not stalled,
// and stop at the first hit; an empty table, learn into a full table and both
// deletes finish without a scan.
// The result sits in an output register; a stalled result holds the scan.
// Reset is synchronous and needs no clearing pass: only slots below the count
// are ever used.
`timescale 1ns / 1ps

module rf_remote_learn_table import rrlt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [REG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic [CODE_W-1:0] in_rf_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [OUT_W-1:0]  out_slot_number,
  output logic [OUT_W-1:0]  out_stored_count
);

  cmd_t  cmd;
  stat_t stat;

  rrlt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  rrlt_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_operation     (in_operation),
    .in_rf_code       (in_rf_code),
    .cmd              (cmd),
    .stat             (stat),
    .out_status       (out_status),
    .out_slot_number  (out_slot_number),
    .out_stored_count (out_stored_count)
  );

endmodule

// File: rtl/rrlt_checker.sv
// Port-level checks for the RF remote learn table, bound to the top level.
// Depends on rrlt_pkg.
`timescale 1ns / 1ps

module rrlt_checker import rrlt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       out_status,
  input logic [OUT_W-1:0] out_slot_number,
  input logic [OUT_W-1:0] out_stored_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_slot_number) && $stable(out_stored_count))
    else $error("result changed while stalled");

  // failures never name a slot
  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_EXISTS ||
      out_status == ST_UNKNOWN || out_status == ST_EMPTY) |-> out_slot_number == '0)
    else $error("failed item reports a slot");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_stored_count == OUT_W'(SLOTS))
    else $error("table full reported below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_stored_count == '0)
    else $error("table empty reported with entries");

  // slot number never exceeds the count it was reported with, plus the removed one
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stored_count <= OUT_W'(SLOTS) &&
      out_slot_number <= out_stored_count + 1'b1)
    else $error("slot number out of range");

endmodule

bind rf_remote_learn_table rrlt_checker u_rrlt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_slot_number  (out_slot_number),
  .out_stored_count (out_stored_count)
);
